// File: rtl/dcs_pkg.sv
package dcs_pkg;

	// Valve count of the device; bits at or above it always read closed
	localparam int NUM_VALVES = 16;
	localparam int VALVE_W    = 16;
	localparam logic [VALVE_W-1:0] VALVE_LIMIT = (NUM_VALVES >= VALVE_W) ?
		{VALVE_W{1'b1}} : VALVE_W'((64'd1 << NUM_VALVES) - 64'd1);

	// Register bank
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_DRY_LIMIT     = 3'd0;
	localparam logic [2:0] REG_MAX_ROUNDS    = 3'd1;
	localparam logic [2:0] REG_CLAMP_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_PUMP_TIME     = 3'd3;
	localparam logic [2:0] REG_CLAMP_MASK    = 3'd4;
	localparam logic [2:0] REG_RELEASE_MASK  = 3'd5;
	localparam logic [2:0] REG_UP_INDEX      = 3'd6;
	localparam logic [2:0] REG_DOWN_INDEX    = 3'd7;

	// Timer and leak-cycle command codes
	localparam logic [1:0] TMR_NONE     = 2'd0;
	localparam logic [1:0] TMR_STOP     = 2'd1;
	localparam logic [1:0] TMR_START    = 2'd2;
	localparam logic [1:0] LEAK_NONE    = 2'd0;
	localparam logic [1:0] LEAK_STOP    = 2'd1;
	localparam logic [1:0] LEAK_START   = 2'd2;
	localparam logic [1:0] LEAK_RESTART = 2'd3;

	// Error bits
	localparam logic [4:0] ERR_DRY_NEEDED = 5'b00001;
	localparam logic [4:0] ERR_DRY_FAIL   = 5'b00010;
	localparam logic [4:0] ERR_DOWN       = 5'b00100;
	localparam logic [4:0] ERR_UP         = 5'b01000;
	localparam logic [4:0] ERR_GUARD      = 5'b10000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_UP   = 2'd2,
		PH_PUMP = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_INIT        = 3'd0,
		EV_START       = 3'd1,
		EV_STOP        = 3'd2,
		EV_DELAY_OVER  = 3'd3,
		EV_UP_SENSOR   = 3'd4,
		EV_DOWN_SENSOR = 3'd5,
		EV_GUARD       = 3'd6,
		EV_TIMEOUT     = 3'd7
	} event_t;

	typedef struct packed {
		logic [15:0]        dry_limit;
		logic [7:0]         max_pump_rounds;
		logic [7:0]         clamp_timeout_s;
		logic [7:0]         pump_time_s;
		logic [VALVE_W-1:0] clamp_valve_mask;
		logic [VALVE_W-1:0] release_valve_mask;
		logic [3:0]         up_valve_index;
		logic [3:0]         down_valve_index;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [7:0]         rounds;
		logic [VALVE_W-1:0] valves;
		logic               saved_up;
		logic               saved_down;
	} seq_state_t;

	typedef struct packed {
		phase_t             phase;
		logic [VALVE_W-1:0] valve_mask;
		logic [4:0]         error_set;
		logic [4:0]         error_clear;
		logic               run_status_set;
		logic [1:0]         cyl_timer_cmd;
		logic [1:0]         pump_timer_cmd;
		logic [1:0]         leak_cycle_cmd;
		logic               report_phase;
	} result_t;

endpackage

// File: rtl/drying_cycle_sequencer_unit.sv
// Drying cycle sequencer.
// Input channel (in_valid/in_stall) carries one event per transaction: mode,
// sensor_level and pressure. Output channel (out_valid/out_stall) carries one
// result transaction per event: new phase, valve mask, error set/clear masks,
// run status, cylinder/pump timer commands, leak-cycle command and report flag.
// Transactions complete on a rising edge with valid high and stall low.
// Path: an accepted event goes from the input register through the event
// decode and state update into the output register. Throughput: one event per
// cycle while the receiver does not stall.
// The sequencer state (phase, pump rounds, valves, saved cylinder bits) is
// updated when an event moves from the input register into the output
// register, so each event sees the state left by the one before it.
// When the receiver stalls, the result holds; one more event waits in the
// input register and in_stall rises only when both stages are full.
// Reset (arst_n low) empties both stages and returns to idle with zero pump
// rounds, all valves closed and register defaults loaded.
// The user must do configuration through the APB port while no event is in
// flight; the block does not enforce it. Registers sit at byte address 4*index, pready is always high.
module drying_cycle_sequencer_unit
	import dcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// events
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic              sensor_level,
	input  logic [15:0]       pressure,
	// results
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        phase,
	output logic [VALVE_W-1:0] valve_mask,
	output logic [4:0]        error_set,
	output logic [4:0]        error_clear,
	output logic              run_status_set,
	output logic [1:0]        cyl_timer_cmd,
	output logic [1:0]        pump_timer_cmd,
	output logic [1:0]        leak_cycle_cmd,
	output logic              report_phase
);

	cfg_t        cfg;
	seq_state_t  st_q;
	seq_state_t  st_nxt;
	result_t     res_d;
	result_t     res_q;
	logic        valid_s1;
	event_t      mode_s1;
	logic        level_s1;
	logic [15:0] pressure_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;
	logic        in_take;

	dcs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1     <= event_t'(mode);
			level_s1    <= sensor_level;
			pressure_s1 <= pressure;
		end
	end

	dcs_event_logic u_logic (
		.mode         (mode_s1),
		.sensor_level (level_s1),
		.pressure     (pressure_s1),
		.cfg          (cfg),
		.st           (st_q),
		.nxt          (st_nxt),
		.res          (res_d)
	);

	// Sequencer state, updated as the event retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.rounds     <= 8'd0;
			st_q.valves     <= '0;
			st_q.saved_up   <= 1'b0;
			st_q.saved_down <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign phase          = res_q.phase;
	assign valve_mask     = res_q.valve_mask;
	assign error_set      = res_q.error_set;
	assign error_clear    = res_q.error_clear;
	assign run_status_set = res_q.run_status_set;
	assign cyl_timer_cmd  = res_q.cyl_timer_cmd;
	assign pump_timer_cmd = res_q.pump_timer_cmd;
	assign leak_cycle_cmd = res_q.leak_cycle_cmd;
	assign report_phase   = res_q.report_phase;

`ifndef SYNTHESIS
	// state only moves when an event retires
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("sequencer state changed without a retiring event");

	// idle always carries a cleared round count
	a_idle_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) |-> (st_q.rounds == 8'd0))
		else $error("pump rounds nonzero in idle");

	// no valve beyond the device is ever open
	a_valve_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.valves & ~VALVE_LIMIT) == '0)
		else $error("valve bit set outside the device");

	// a phase report never announces idle
	a_report_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.report_phase) |-> (res_q.phase != PH_IDLE))
		else $error("phase report with idle phase");
`endif

endmodule

// File: rtl/dcs_cfg_regs.sv
module dcs_cfg_regs
	import dcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] reg_sel;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_limit          <= 16'd0;
			cfg_q.max_pump_rounds    <= 8'd20;
			cfg_q.clamp_timeout_s    <= 8'd25;
			cfg_q.pump_time_s        <= 8'd30;
			cfg_q.clamp_valve_mask   <= '0;
			cfg_q.release_valve_mask <= '0;
			cfg_q.up_valve_index     <= 4'd0;
			cfg_q.down_valve_index   <= 4'd1;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DRY_LIMIT:     cfg_q.dry_limit          <= pwdata[15:0];
				REG_MAX_ROUNDS:    cfg_q.max_pump_rounds    <= pwdata[7:0];
				REG_CLAMP_TIMEOUT: cfg_q.clamp_timeout_s    <= pwdata[7:0];
				REG_PUMP_TIME:     cfg_q.pump_time_s        <= pwdata[7:0];
				REG_CLAMP_MASK:    cfg_q.clamp_valve_mask   <= pwdata[VALVE_W-1:0];
				REG_RELEASE_MASK:  cfg_q.release_valve_mask <= pwdata[VALVE_W-1:0];
				REG_UP_INDEX:      cfg_q.up_valve_index     <= pwdata[3:0];
				REG_DOWN_INDEX:    cfg_q.down_valve_index   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_DRY_LIMIT:     prdata[15:0]        = cfg_q.dry_limit;
			REG_MAX_ROUNDS:    prdata[7:0]         = cfg_q.max_pump_rounds;
			REG_CLAMP_TIMEOUT: prdata[7:0]         = cfg_q.clamp_timeout_s;
			REG_PUMP_TIME:     prdata[7:0]         = cfg_q.pump_time_s;
			REG_CLAMP_MASK:    prdata[VALVE_W-1:0] = cfg_q.clamp_valve_mask;
			REG_RELEASE_MASK:  prdata[VALVE_W-1:0] = cfg_q.release_valve_mask;
			REG_UP_INDEX:      prdata[3:0]         = cfg_q.up_valve_index;
			REG_DOWN_INDEX:    prdata[3:0]         = cfg_q.down_valve_index;
			default: ;
		endcase
	end

endmodule

// File: rtl/dcs_event_logic.sv
module dcs_event_logic
	import dcs_pkg::*;
(
	input  event_t      mode,
	input  logic        sensor_level,
	input  logic [15:0] pressure,
	input  cfg_t        cfg,
	input  seq_state_t  st,
	output seq_state_t  nxt,
	output result_t     res
);

	logic               dry_done;
	logic               dry_fail;
	logic               up_ok;
	logic               down_ok;
	logic               up_bit;
	logic               down_bit;
	logic [7:0]         rounds_inc;
	logic [VALVE_W-1:0] clamp_lim;
	logic [VALVE_W-1:0] release_lim;
	logic [VALVE_W-1:0] guard_closed;
	logic [VALVE_W-1:0] guard_restored;

	// Pump round decisions
	assign dry_done   = pressure < cfg.dry_limit;
	assign dry_fail   = !dry_done && (st.rounds > cfg.max_pump_rounds);
	assign rounds_inc = (st.rounds == 8'hFF) ? st.rounds : st.rounds + 8'd1;

	assign clamp_lim   = cfg.clamp_valve_mask & VALVE_LIMIT;
	assign release_lim = cfg.release_valve_mask & VALVE_LIMIT;

	// Cylinder valve bits for the guard
	assign up_ok    = int'(cfg.up_valve_index) < NUM_VALVES;
	assign down_ok  = int'(cfg.down_valve_index) < NUM_VALVES;
	assign up_bit   = up_ok & st.valves[cfg.up_valve_index];
	assign down_bit = down_ok & st.valves[cfg.down_valve_index];

	always_comb begin
		guard_closed   = st.valves;
		guard_restored = st.valves;
		if (up_ok) begin
			guard_closed[cfg.up_valve_index]   = 1'b0;
			guard_restored[cfg.up_valve_index] = st.saved_up;
		end
		// down bit written last when both indices match
		if (down_ok) begin
			guard_closed[cfg.down_valve_index]   = 1'b0;
			guard_restored[cfg.down_valve_index] = st.saved_down;
		end
	end

	// Next state
	always_comb begin
		nxt = st;
		unique case (mode)
			EV_INIT: begin
				nxt.phase  = PH_IDLE;
				nxt.rounds = 8'd0;
			end
			EV_START: begin
				if (st.phase == PH_IDLE) begin
					nxt.phase  = PH_DOWN;
					nxt.valves = clamp_lim;
				end
			end
			EV_STOP: begin
				unique case (st.phase)
					PH_DOWN, PH_PUMP: begin
						nxt.phase  = PH_UP;
						nxt.valves = release_lim;
					end
					PH_UP: begin
						nxt.phase  = PH_IDLE;
						nxt.rounds = 8'd0;
					end
					default: ;
				endcase
			end
			EV_DELAY_OVER: begin
				if (st.phase == PH_PUMP) begin
					if (dry_done || dry_fail) begin
						nxt.phase  = PH_UP;
						nxt.valves = release_lim;
					end else begin
						nxt.rounds = rounds_inc;
						nxt.valves = clamp_lim;
					end
				end
			end
			EV_UP_SENSOR: begin
				if (st.phase == PH_UP && sensor_level) begin
					nxt.phase  = PH_IDLE;
					nxt.rounds = 8'd0;
				end
			end
			EV_DOWN_SENSOR: begin
				if (st.phase == PH_DOWN && sensor_level) begin
					nxt.phase  = PH_PUMP;
					nxt.rounds = rounds_inc;
					nxt.valves = clamp_lim;
				end
			end
			EV_GUARD: begin
				if (sensor_level) begin
					nxt.saved_up   = up_bit;
					nxt.saved_down = down_bit;
					nxt.valves     = guard_closed;
				end else begin
					nxt.valves = guard_restored;
				end
			end
			EV_TIMEOUT: begin
				if (st.phase == PH_DOWN) begin
					nxt.phase  = PH_UP;
					nxt.valves = release_lim;
				end else if (st.phase == PH_UP) begin
					nxt.phase  = PH_IDLE;
					nxt.rounds = 8'd0;
				end
			end
			default: ;
		endcase
	end

	// Commands and report flags
	always_comb begin
		res                = '0;
		res.phase          = nxt.phase;
		res.valve_mask     = nxt.valves;
		res.cyl_timer_cmd  = TMR_NONE;
		res.pump_timer_cmd = TMR_NONE;
		res.leak_cycle_cmd = LEAK_NONE;
		unique case (mode)
			EV_INIT: res.error_clear = ERR_DRY_NEEDED;
			EV_START: begin
				if (st.phase == PH_IDLE) begin
					res.run_status_set = 1'b1;
					res.cyl_timer_cmd  = TMR_START;
					res.report_phase   = 1'b1;
				end
			end
			EV_STOP: begin
				unique case (st.phase)
					PH_DOWN: begin
						res.cyl_timer_cmd = TMR_START;
						res.report_phase  = 1'b1;
					end
					PH_PUMP: begin
						res.pump_timer_cmd = TMR_STOP;
						res.leak_cycle_cmd = LEAK_STOP;
						res.cyl_timer_cmd  = TMR_START;
						res.report_phase   = 1'b1;
					end
					PH_UP: res.cyl_timer_cmd = TMR_STOP;
					default: ;
				endcase
			end
			EV_DELAY_OVER: begin
				if (st.phase == PH_PUMP) begin
					res.report_phase = 1'b1;
					if (dry_done || dry_fail) begin
						res.pump_timer_cmd = TMR_STOP;
						res.leak_cycle_cmd = LEAK_STOP;
						res.cyl_timer_cmd  = TMR_START;
						res.error_set      = dry_fail ? ERR_DRY_FAIL : 5'd0;
					end else begin
						res.pump_timer_cmd = TMR_START;
						res.leak_cycle_cmd = LEAK_RESTART;
					end
				end
			end
			EV_UP_SENSOR: begin
				if (st.phase == PH_UP && sensor_level) begin
					res.cyl_timer_cmd = TMR_STOP;
				end
			end
			EV_DOWN_SENSOR: begin
				if (st.phase == PH_DOWN && sensor_level) begin
					res.cyl_timer_cmd  = TMR_STOP;
					res.pump_timer_cmd = TMR_START;
					res.leak_cycle_cmd = LEAK_START;
					res.report_phase   = 1'b1;
					res.error_clear    = ERR_DOWN;
				end
			end
			EV_GUARD: begin
				if (sensor_level) begin
					res.error_set = ERR_GUARD;
				end else begin
					res.error_clear = ERR_GUARD;
				end
			end
			EV_TIMEOUT: begin
				if (st.phase == PH_DOWN) begin
					res.error_set     = ERR_DOWN;
					res.cyl_timer_cmd = TMR_START;
					res.report_phase  = 1'b1;
				end else if (st.phase == PH_UP) begin
					res.error_set     = ERR_UP;
					res.cyl_timer_cmd = TMR_STOP;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: test/tb_drying_cycle_sequencer_unit.sv
module tb_drying_cycle_sequencer_unit
	import dcs_pkg::*;
;

	// Clock, reset and DUT ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        mode = '0;
	logic              sensor_level = 1'b0;
	logic [15:0]       pressure = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        phase;
	logic [VALVE_W-1:0] valve_mask;
	logic [4:0]        error_set;
	logic [4:0]        error_clear;
	logic              run_status_set;
	logic [1:0]        cyl_timer_cmd;
	logic [1:0]        pump_timer_cmd;
	logic [1:0]        leak_cycle_cmd;
	logic              report_phase;

	// Shadow of the sequencer: register bank and state
	cfg_t       cfg;
	seq_state_t plant;
	result_t    sequencer_outcomes [$];
	int         mismatch_count = 0;

	// Idle control shared by sender and receiver
	bit calm = 1'b0;
	int hold_requests = 0;

	// Directed events, run with the configuration below
	localparam logic [15:0] DIR_LIMIT   = 16'h1000;
	localparam logic [15:0] DIR_CLAMP   = 16'hC3A5;
	localparam logic [15:0] DIR_RELEASE = 16'h3C5A;
	// clamp mask with the cylinder valves (bits 15 and 0) frozen
	localparam logic [15:0] DIR_GUARDED = 16'h43A4;
	localparam result_t     UNTYPED     = '0;

	typedef struct {
		event_t      ev;
		logic        lvl;
		logic [15:0] pres;
		bit          typed;
		result_t     want;
	} script_row_t;

	script_row_t script [28] = '{
		// nothing applies in idle
		'{EV_TIMEOUT, 1'b0, 16'h0000, 1'b1,
			'{PH_IDLE, 16'h0000, 5'd0, 5'd0, 1'b0, TMR_NONE, TMR_NONE, LEAK_NONE, 1'b0}},
		// guard release with nothing saved
		'{EV_GUARD, 1'b0, 16'h0000, 1'b1,
			'{PH_IDLE, 16'h0000, 5'd0, ERR_GUARD, 1'b0, TMR_NONE, TMR_NONE, LEAK_NONE, 1'b0}},
		'{EV_INIT, 1'b1, 16'hFFFF, 1'b1,
			'{PH_IDLE, 16'h0000, 5'd0, ERR_DRY_NEEDED, 1'b0, TMR_NONE, TMR_NONE, LEAK_NONE,
				1'b0}},
		'{EV_DELAY_OVER, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_UP_SENSOR, 1'b1, 16'h0000, 1'b0, UNTYPED},
		'{EV_START, 1'b0, 16'h0000, 1'b1,
			'{PH_DOWN, DIR_CLAMP, 5'd0, 5'd0, 1'b1, TMR_START, TMR_NONE, LEAK_NONE, 1'b1}},
		'{EV_DOWN_SENSOR, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_DOWN_SENSOR, 1'b1, 16'h0000, 1'b1,
			'{PH_PUMP, DIR_CLAMP, 5'd0, ERR_DOWN, 1'b0, TMR_STOP, TMR_START, LEAK_START, 1'b1}},
		'{EV_GUARD, 1'b1, 16'h0000, 1'b1,
			'{PH_PUMP, DIR_GUARDED, ERR_GUARD, 5'd0, 1'b0, TMR_NONE, TMR_NONE, LEAK_NONE, 1'b0}},
		'{EV_GUARD, 1'b0, 16'h0000, 1'b0, UNTYPED},
		// pump timer stop and start in one event: start alone, leak restarts
		'{EV_DELAY_OVER, 1'b0, 16'hFFFF, 1'b1,
			'{PH_PUMP, DIR_CLAMP, 5'd0, 5'd0, 1'b0, TMR_NONE, TMR_START, LEAK_RESTART, 1'b1}},
		// rounds past the maximum: dry failure
		'{EV_DELAY_OVER, 1'b0, 16'hFFFF, 1'b1,
			'{PH_UP, DIR_RELEASE, ERR_DRY_FAIL, 5'd0, 1'b0, TMR_START, TMR_STOP, LEAK_STOP, 1'b1}},
		'{EV_UP_SENSOR, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_UP_SENSOR, 1'b1, 16'h0000, 1'b0, UNTYPED},
		'{EV_START, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_DOWN_SENSOR, 1'b1, 16'h0000, 1'b0, UNTYPED},
		'{EV_STOP, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_TIMEOUT, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_START, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_TIMEOUT, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_STOP, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_START, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_STOP, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_INIT, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_START, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_DOWN_SENSOR, 1'b1, 16'h0000, 1'b0, UNTYPED},
		// pressure below the limit ends drying
		'{EV_DELAY_OVER, 1'b0, 16'h0000, 1'b0, UNTYPED},
		'{EV_INIT, 1'b0, 16'h0000, 1'b0, UNTYPED}
	};

	drying_cycle_sequencer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.sensor_level   (sensor_level),
		.pressure       (pressure),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.phase          (phase),
		.valve_mask     (valve_mask),
		.error_set      (error_set),
		.error_clear    (error_clear),
		.run_status_set (run_status_set),
		.cyl_timer_cmd  (cyl_timer_cmd),
		.pump_timer_cmd (pump_timer_cmd),
		.leak_cycle_cmd (leak_cycle_cmd),
		.report_phase   (report_phase)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Phase transitions of the sequencer shadow
	function automatic void enter_idle();
		plant.phase  = PH_IDLE;
		plant.rounds = '0;
	endfunction

	function automatic void enter_up(inout result_t r);
		plant.phase     = PH_UP;
		plant.valves    = cfg.release_valve_mask & VALVE_LIMIT;
		r.cyl_timer_cmd = TMR_START;
		r.report_phase  = 1'b1;
	endfunction

	function automatic void enter_pump(inout result_t r);
		plant.phase = PH_PUMP;
		if (plant.rounds != 8'hFF)
			plant.rounds = plant.rounds + 8'd1;
		plant.valves     = cfg.clamp_valve_mask & VALVE_LIMIT;
		r.pump_timer_cmd = TMR_START;
		// a leak stop earlier in the same event turns into a restart
		r.leak_cycle_cmd = (r.leak_cycle_cmd == LEAK_STOP) ? LEAK_RESTART : LEAK_START;
		r.report_phase   = 1'b1;
	endfunction

	// Valves beyond the device read closed and ignore writes
	function automatic logic valve_at(logic [3:0] idx);
		return (int'(idx) < NUM_VALVES) ? plant.valves[idx] : 1'b0;
	endfunction

	function automatic void set_valve(logic [3:0] idx, logic b);
		if (int'(idx) < NUM_VALVES)
			plant.valves[idx] = b;
	endfunction

	// Next state and result for one event
	function automatic result_t predict_sequencer(event_t ev, logic lvl, logic [15:0] pres);
		result_t r;
		r = '0;
		case (ev)
		EV_INIT: begin
			r.error_clear = ERR_DRY_NEEDED;
			enter_idle();
		end
		EV_START: if (plant.phase == PH_IDLE) begin
			r.run_status_set = 1'b1;
			plant.phase      = PH_DOWN;
			plant.valves     = cfg.clamp_valve_mask & VALVE_LIMIT;
			r.cyl_timer_cmd  = TMR_START;
			r.report_phase   = 1'b1;
		end
		EV_STOP: case (plant.phase)
			PH_DOWN: begin
				r.cyl_timer_cmd = TMR_STOP;
				enter_up(r);
			end
			PH_PUMP: begin
				r.pump_timer_cmd = TMR_STOP;
				r.leak_cycle_cmd = LEAK_STOP;
				enter_up(r);
			end
			PH_UP: begin
				r.cyl_timer_cmd = TMR_STOP;
				enter_idle();
			end
			default: ;
		endcase
		EV_DELAY_OVER: if (plant.phase == PH_PUMP) begin
			r.pump_timer_cmd = TMR_STOP;
			r.leak_cycle_cmd = LEAK_STOP;
			if (pres < cfg.dry_limit) begin
				enter_up(r);
			end else if (plant.rounds > cfg.max_pump_rounds) begin
				r.error_set = ERR_DRY_FAIL;
				enter_up(r);
			end else begin
				enter_pump(r);
			end
		end
		EV_UP_SENSOR: if (plant.phase == PH_UP && lvl) begin
			r.cyl_timer_cmd = TMR_STOP;
			enter_idle();
		end
		EV_DOWN_SENSOR: if (plant.phase == PH_DOWN && lvl) begin
			r.cyl_timer_cmd = TMR_STOP;
			enter_pump(r);
			r.error_clear = ERR_DOWN;
		end
		EV_GUARD: if (lvl) begin
			plant.saved_up   = valve_at(cfg.up_valve_index);
			plant.saved_down = valve_at(cfg.down_valve_index);
			set_valve(cfg.up_valve_index, 1'b0);
			set_valve(cfg.down_valve_index, 1'b0);
			r.error_set = ERR_GUARD;
		end else begin
			// down bit last, so it wins on a shared index
			set_valve(cfg.up_valve_index, plant.saved_up);
			set_valve(cfg.down_valve_index, plant.saved_down);
			r.error_clear = ERR_GUARD;
		end
		default: if (plant.phase == PH_DOWN) begin
			r.error_set     = ERR_DOWN;
			r.cyl_timer_cmd = TMR_STOP;
			enter_up(r);
		end else if (plant.phase == PH_UP) begin
			r.error_set     = ERR_UP;
			r.cyl_timer_cmd = TMR_STOP;
			enter_idle();
		end
		endcase
		r.phase      = phase_t'(plant.phase);
		r.valve_mask = plant.valves;
		return r;
	endfunction

	// Mismatch reporting
	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// APB register write, shadowed into cfg with the register width
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_DRY_LIMIT:     cfg.dry_limit          = val[15:0];
		REG_MAX_ROUNDS:    cfg.max_pump_rounds    = val[7:0];
		REG_CLAMP_TIMEOUT: cfg.clamp_timeout_s    = val[7:0];
		REG_PUMP_TIME:     cfg.pump_time_s        = val[7:0];
		REG_CLAMP_MASK:    cfg.clamp_valve_mask   = val[15:0];
		REG_RELEASE_MASK:  cfg.release_valve_mask = val[15:0];
		REG_UP_INDEX:      cfg.up_valve_index     = val[3:0];
		default:           cfg.down_valve_index   = val[3:0];
		endcase
	endtask

	// Full register set; upper bits carry junk that must be dropped
	task automatic configure(logic [15:0] dry, logic [7:0] rounds, logic [7:0] ctime,
			logic [7:0] ptime, logic [15:0] cmask, logic [15:0] rmask,
			logic [3:0] up, logic [3:0] down);
		write_reg(REG_DRY_LIMIT,     {16'($urandom), dry});
		write_reg(REG_MAX_ROUNDS,    {24'($urandom), rounds});
		write_reg(REG_CLAMP_TIMEOUT, {24'($urandom), ctime});
		write_reg(REG_PUMP_TIME,     {24'($urandom), ptime});
		write_reg(REG_CLAMP_MASK,    {16'($urandom), cmask});
		write_reg(REG_RELEASE_MASK,  {16'($urandom), rmask});
		write_reg(REG_UP_INDEX,      {28'($urandom), up});
		write_reg(REG_DOWN_INDEX,    {28'($urandom), down});
		// bus back to idle after the last write
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one event; returns at the edge that accepts it
	task automatic deliver(event_t ev, logic lvl, logic [15:0] pres, bit typed, result_t want);
		int gap;
		result_t forecast;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= ev;
		sensor_level <= lvl;
		pressure     <= pres;
		do @(posedge clk); while (in_stall);
		forecast = predict_sequencer(ev, lvl, pres);
		sequencer_outcomes.push_back(typed ? want : forecast);
	endtask

	// Stop sending and wait for every pending result
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sequencer_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random events, mostly ones that move the current phase along
	task automatic drive_random(int count);
		event_t      ev;
		logic        lvl;
		logic [15:0] pres;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			lvl  = 1'b1;
			pres = 16'($urandom);
			if (pick < 15) begin
				ev  = event_t'($urandom_range(0, 7));
				lvl = 1'($urandom_range(0, 1));
			end else begin
				case (plant.phase)
				PH_IDLE: ev = (pick < 25) ? EV_GUARD : EV_START;
				PH_DOWN: ev = (pick < 25) ? EV_GUARD : (pick < 35) ? EV_TIMEOUT :
					(pick < 45) ? EV_STOP : EV_DOWN_SENSOR;
				PH_PUMP: ev = (pick < 25) ? EV_GUARD : (pick < 32) ? EV_STOP :
					(pick < 36) ? EV_INIT : EV_DELAY_OVER;
				default: ev = (pick < 25) ? EV_GUARD : (pick < 35) ? EV_TIMEOUT :
					(pick < 45) ? EV_STOP : EV_UP_SENSOR;
				endcase
				if (ev == EV_GUARD)
					lvl = 1'($urandom_range(0, 1));
				// pressure right around the limit
				if (ev == EV_DELAY_OVER && pick[0])
					pres = cfg.dry_limit + 16'($urandom_range(0, 6)) - 16'd3;
			end
			deliver(ev, lvl, pres, 1'b0, UNTYPED);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sequencer_outcomes.size() == 0) begin
				report_mismatch("result transaction with no event pending");
			end else begin
				want = sequencer_outcomes.pop_front();
				check_field("phase", 32'(phase), 32'(want.phase));
				check_field("valve_mask", 32'(valve_mask), 32'(want.valve_mask));
				check_field("error_set", 32'(error_set), 32'(want.error_set));
				check_field("error_clear", 32'(error_clear), 32'(want.error_clear));
				check_field("run_status_set", 32'(run_status_set),
					32'(want.run_status_set));
				check_field("cyl_timer_cmd", 32'(cyl_timer_cmd), 32'(want.cyl_timer_cmd));
				check_field("pump_timer_cmd", 32'(pump_timer_cmd),
					32'(want.pump_timer_cmd));
				check_field("leak_cycle_cmd", 32'(leak_cycle_cmd),
					32'(want.leak_cycle_cmd));
				check_field("report_phase", 32'(report_phase), 32'(want.report_phase));
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served++;
				out_stall <= 1'b1;
				repeat (64) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (1 + pick_gap()) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus
	initial begin
		int         p;
		logic [3:0] up_idx;
		cfg = '{dry_limit: 16'd0, max_pump_rounds: 8'd20, clamp_timeout_s: 8'd25,
			pump_time_s: 8'd30, clamp_valve_mask: '0, release_valve_mask: '0,
			up_valve_index: 4'd0, down_valve_index: 4'd1};
		plant = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events
		configure(DIR_LIMIT, 8'd1, 8'd0, 8'd255, DIR_CLAMP, DIR_RELEASE, 4'd15, 4'd0);
		foreach (script[i])
			deliver(script[i].ev, script[i].lvl, script[i].pres, script[i].typed, script[i].want);
		quiesce();

		// never dry, no round limit: the counter saturates; shared cylinder index
		configure(16'h0000, 8'd255, 8'd255, 8'd0, 16'hFFFF, 16'h0000, 4'd7, 4'd7);
		deliver(EV_START, 1'b0, 16'h0000, 1'b0, UNTYPED);
		deliver(EV_DOWN_SENSOR, 1'b1, 16'h0000, 1'b0, UNTYPED);
		repeat (300)
			deliver(EV_DELAY_OVER, 1'b0, 16'($urandom), 1'b0, UNTYPED);
		deliver(EV_GUARD, 1'b1, 16'h0000, 1'b0, UNTYPED);
		deliver(EV_GUARD, 1'b0, 16'h0000, 1'b0, UNTYPED);
		deliver(EV_STOP, 1'b0, 16'h0000, 1'b0, UNTYPED);
		quiesce();

		// random phases, each with its own settings
		for (p = 0; p < 8; p++) begin
			up_idx = 4'($urandom);
			if (p == 0)
				configure(16'hFFFF, 8'd0, 8'd0, 8'd255, 16'h0000, 16'hFFFF, 4'd0, 4'd15);
			else
				configure(16'($urandom), (p % 2) ? 8'($urandom_range(0, 6)) : 8'($urandom),
					8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					up_idx, (p % 3 == 0) ? up_idx : 4'($urandom));
			calm <= (p % 3 == 2) || (p == 4);
			// back-to-back events against a receiver that holds off
			if (p == 4)
				hold_requests <= hold_requests + 1;
			drive_random(200);
			quiesce();
		end

		calm <= 1'b1;
		repeat (8) @(posedge clk);
		if (sequencer_outcomes.size() != 0)
			report_mismatch("results still pending at end of run");
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule
